// ===== rtl/crs_pkg.sv =====
// ============================================================================
// Conic residual statistics package
// Shared constants, register codes, records and state types of the block.
// ============================================================================
package crs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ACC_W      = 100;
    localparam int SUM_W      = 32 + IDX_W;
    localparam int SQ_W       = 64 + IDX_W;
    localparam int DIV_W      = SQ_W;

    typedef enum logic [2:0] {
        REG_COEF_A    = 3'd0,
        REG_COEF_B    = 3'd1,
        REG_COEF_C    = 3'd2,
        REG_COEF_D    = 3'd3,
        REG_COEF_E    = 3'd4,
        REG_COEF_F    = 3'd5,
        REG_THRESHOLD = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] coef_e;
        logic signed [31:0] coef_f;
        logic [30:0]        thr;
    } conic_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] r;
        logic               inl;
        logic               last;
    } point_rec_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_FIN
    } front_state_t;

    typedef enum logic [3:0] {
        S_XX,
        S_XY,
        S_YY,
        S_A_LO,
        S_A_HI,
        S_B_LO,
        S_B_HI,
        S_C_LO,
        S_C_HI,
        S_D,
        S_E,
        S_DONE
    } mul_step_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MEAN,
        B_SWEEP,
        B_DRAIN,
        B_VAR,
        B_SQRT,
        B_EMIT
    } back_state_t;

endpackage

// ===== rtl/crs_front.sv =====
// ============================================================================
// Conic residual front end
// Accepts points and forms the rounded, saturated residual on one shared
// multiplier, then classifies the point and hands a record to the queue.
// ============================================================================
module crs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    input  logic                last_point,
    input  crs_pkg::conic_cfg_t cfg,
    input  logic                q_full,
    output logic                busy,
    output logic                rec_valid,
    output crs_pkg::point_rec_t rec
);

    crs_pkg::front_state_t state_reg, state_next;
    crs_pkg::mul_step_t    step_reg, ptag_reg;
    logic                  pvld_reg;
    logic [crs_pkg::IDX_W-1:0] idx_reg;

    logic signed [31:0] x_reg, y_reg;
    logic               last_reg;
    logic signed [63:0] xx_reg, xy_reg, yy_reg;
    logic signed [crs_pkg::ACC_W-1:0] acc_reg;
    logic signed [65:0] prod_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic signed [crs_pkg::ACC_W-1:0] ext, term, acc_init, sh;
    logic               pos_ovf, neg_ovf, last_eff;
    logic signed [31:0] r;
    logic [31:0]        r_mag;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crs_pkg::F_IDLE: if (start) state_next = crs_pkg::F_MUL;
            crs_pkg::F_MUL:  if (step_reg == crs_pkg::S_DONE) state_next = crs_pkg::F_FIN;
            crs_pkg::F_FIN:  if (!q_full) state_next = crs_pkg::F_IDLE;
            default:         state_next = crs_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != crs_pkg::F_IDLE);
        rec_valid = (state_reg == crs_pkg::F_FIN) && !q_full;
    end

    // Operand selection for the shared multiplier. Squares and the cross term
    // are split into a low unsigned half and a high signed half.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            crs_pkg::S_XX:   begin op_a = {x_reg[31], x_reg}; op_b = {x_reg[31], x_reg}; end
            crs_pkg::S_XY:   begin op_a = {x_reg[31], x_reg}; op_b = {y_reg[31], y_reg}; end
            crs_pkg::S_YY:   begin op_a = {y_reg[31], y_reg}; op_b = {y_reg[31], y_reg}; end
            crs_pkg::S_A_LO: begin op_a = {cfg.coef_a[31], cfg.coef_a}; op_b = {1'b0, xx_reg[31:0]}; end
            crs_pkg::S_A_HI: begin op_a = {cfg.coef_a[31], cfg.coef_a}; op_b = {xx_reg[63], xx_reg[63:32]}; end
            crs_pkg::S_B_LO: begin op_a = {cfg.coef_b[31], cfg.coef_b}; op_b = {1'b0, xy_reg[31:0]}; end
            crs_pkg::S_B_HI: begin op_a = {cfg.coef_b[31], cfg.coef_b}; op_b = {xy_reg[63], xy_reg[63:32]}; end
            crs_pkg::S_C_LO: begin op_a = {cfg.coef_c[31], cfg.coef_c}; op_b = {1'b0, yy_reg[31:0]}; end
            crs_pkg::S_C_HI: begin op_a = {cfg.coef_c[31], cfg.coef_c}; op_b = {yy_reg[63], yy_reg[63:32]}; end
            crs_pkg::S_D:    begin op_a = {cfg.coef_d[31], cfg.coef_d}; op_b = {x_reg[31], x_reg}; end
            crs_pkg::S_E:    begin op_a = {cfg.coef_e[31], cfg.coef_e}; op_b = {y_reg[31], y_reg}; end
            default:         begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = op_a * op_b;

    always_comb
    begin
        ext = crs_pkg::ACC_W'(prod_reg);
        case (ptag_reg) inside
            crs_pkg::S_A_LO, crs_pkg::S_B_LO, crs_pkg::S_C_LO: term = ext;
            crs_pkg::S_A_HI, crs_pkg::S_B_HI, crs_pkg::S_C_HI: term = ext <<< 32;
            crs_pkg::S_D, crs_pkg::S_E: term = ext <<< crs_pkg::FRAC_BITS;
            default: term = '0;
        endcase
    end

    // The accumulator starts with the constant term and the rounding half.
    assign acc_init = (crs_pkg::ACC_W'(cfg.coef_f) <<< (2 * crs_pkg::FRAC_BITS))
                    + (crs_pkg::ACC_W'(1) <<< (2 * crs_pkg::FRAC_BITS - 1));

    always_comb
    begin
        sh      = acc_reg >>> (2 * crs_pkg::FRAC_BITS);
        pos_ovf = !sh[crs_pkg::ACC_W-1] && (|sh[crs_pkg::ACC_W-2:31]);
        neg_ovf = sh[crs_pkg::ACC_W-1] && !(&sh[crs_pkg::ACC_W-2:31]);
        if (pos_ovf)
            r = 32'sh7FFFFFFF;
        else if (neg_ovf)
            r = 32'sh80000000;
        else
            r = sh[31:0];
        r_mag    = r[31] ? 32'(-r) : 32'(r);
        last_eff = last_reg || (idx_reg == crs_pkg::IDX_W'(crs_pkg::MAX_POINTS - 1));
        rec.idx  = idx_reg;
        rec.r    = r;
        rec.inl  = (r_mag <= {1'b0, cfg.thr});
        rec.last = last_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crs_pkg::F_IDLE;
            step_reg  <= crs_pkg::S_XX;
            ptag_reg  <= crs_pkg::S_XX;
            pvld_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pvld_reg  <= (state_reg == crs_pkg::F_MUL) && (step_reg != crs_pkg::S_DONE);
            ptag_reg  <= step_reg;
            if (state_reg == crs_pkg::F_IDLE && start)
                step_reg <= crs_pkg::S_XX;
            else if (state_reg == crs_pkg::F_MUL && step_reg != crs_pkg::S_DONE)
                step_reg <= crs_pkg::mul_step_t'(step_reg + 4'd1);
            if (rec_valid)
                idx_reg <= last_eff ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (state_reg == crs_pkg::F_IDLE && start)
        begin
            x_reg    <= x_coord;
            y_reg    <= y_coord;
            last_reg <= last_point;
            acc_reg  <= acc_init;
        end
        else if (pvld_reg)
        begin
            acc_reg <= acc_reg + term;
        end
        if (pvld_reg && ptag_reg == crs_pkg::S_XX) xx_reg <= prod_reg[63:0];
        if (pvld_reg && ptag_reg == crs_pkg::S_XY) xy_reg <= prod_reg[63:0];
        if (pvld_reg && ptag_reg == crs_pkg::S_YY) yy_reg <= prod_reg[63:0];
    end

endmodule

// ===== rtl/crs_queue.sv =====
// ============================================================================
// Conic residual record queue
// Two-entry queue that lets the front end run ahead of the statistics side.
// ============================================================================
module crs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crs_pkg::point_rec_t push_rec,
    input  logic                pop,
    output crs_pkg::point_rec_t head,
    output logic                empty,
    output logic                full
);

    crs_pkg::point_rec_t entry_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign head  = entry_reg[rd_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_rec;
    end

endmodule

// ===== rtl/crs_div.sv =====
// ============================================================================
// Conic residual serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module crs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [crs_pkg::DIV_W-1:0]   dividend,
    input  logic [crs_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [crs_pkg::DIV_W-1:0]   quotient
);

    localparam int ITER_W = $clog2(crs_pkg::DIV_W + 1);

    logic [crs_pkg::DIV_W-1:0] q_reg;
    logic [crs_pkg::CNT_W-1:0] rem_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic                      run_reg, done_reg;
    logic [crs_pkg::CNT_W:0]   rem_sh, diff;
    logic                      ge;

    always_comb
    begin
        rem_sh = {rem_reg, q_reg[crs_pkg::DIV_W-1]};
        diff   = rem_sh - {1'b0, divisor};
        ge     = (rem_sh >= {1'b0, divisor});
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                iter_reg <= ITER_W'(crs_pkg::DIV_W);
            end
            else if (run_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[crs_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[crs_pkg::CNT_W-1:0] : rem_sh[crs_pkg::CNT_W-1:0];
        end
    end

endmodule

// ===== rtl/crs_back.sv =====
// ============================================================================
// Conic residual back end
// Stores residuals, keeps the running inlier count and sum, issues results
// and runs mean, deviation sweep, variance and square root at a set's end.
// ============================================================================
module crs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crs_pkg::point_rec_t         head,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        done,
    output logic [11:0]                 point_index,
    output logic                        is_inlier,
    output logic signed [31:0]          residual,
    output logic                        summary_valid,
    output logic [12:0]                 inlier_count,
    output logic signed [31:0]          mean_residual,
    output logic [30:0]                 std_residual,
    output logic                        no_inliers
);

    crs_pkg::back_state_t state_reg, state_next;

    logic [crs_pkg::CNT_W-1:0]        cnt_reg, cnt_fin, stat_cnt_reg;
    logic signed [crs_pkg::SUM_W-1:0] sum_reg, sum_fin, stat_sum_reg;
    logic [crs_pkg::SUM_W-1:0]        sum_mag;
    crs_pkg::point_rec_t              hold_reg;

    logic [32:0]               store [crs_pkg::MAX_POINTS];
    logic [crs_pkg::IDX_W-1:0] sw_reg;
    logic [32:0]               rd_reg;
    logic                      rd_vld, d_vld, sq_vld;
    logic [31:0]               d_reg;
    logic [63:0]               sq_reg;
    logic [crs_pkg::SQ_W-1:0]  sqacc_reg;
    logic signed [31:0]        mean_reg;
    logic signed [32:0]        diff;
    logic [63:0]               v_reg, res_reg, bit_reg, trial;

    logic                      div_start, div_done, pipe_empty;
    logic [crs_pkg::DIV_W-1:0] div_dividend, div_q;

    assign cnt_fin    = cnt_reg + crs_pkg::CNT_W'(head.inl);
    assign sum_fin    = sum_reg + (head.inl ? crs_pkg::SUM_W'(head.r) : '0);
    assign sum_mag    = sum_fin[crs_pkg::SUM_W-1] ? crs_pkg::SUM_W'(-sum_fin)
                                                  : crs_pkg::SUM_W'(sum_fin);
    assign pipe_empty = !rd_vld && !d_vld && !sq_vld;
    assign diff       = {rd_reg[31], rd_reg[31:0]} - {mean_reg[31], mean_reg};
    assign trial      = res_reg + bit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crs_pkg::B_IDLE:
                if (!q_empty && head.last)
                    state_next = (cnt_fin == '0) ? crs_pkg::B_EMIT : crs_pkg::B_MEAN;
            crs_pkg::B_MEAN:  if (div_done) state_next = crs_pkg::B_SWEEP;
            crs_pkg::B_SWEEP: if (sw_reg == hold_reg.idx) state_next = crs_pkg::B_DRAIN;
            crs_pkg::B_DRAIN: if (pipe_empty) state_next = crs_pkg::B_VAR;
            crs_pkg::B_VAR:   if (div_done) state_next = crs_pkg::B_SQRT;
            crs_pkg::B_SQRT:  if (bit_reg[0]) state_next = crs_pkg::B_EMIT;
            crs_pkg::B_EMIT:  state_next = crs_pkg::B_IDLE;
            default:          state_next = crs_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = (state_reg == crs_pkg::B_IDLE) && !q_empty;
        div_start    = (pop && head.last && cnt_fin != '0)
                    || (state_reg == crs_pkg::B_DRAIN && pipe_empty);
        div_dividend = (state_reg == crs_pkg::B_DRAIN) ? crs_pkg::DIV_W'(sqacc_reg)
                                                       : crs_pkg::DIV_W'(sum_mag);
    end

    // The mean divides the final sum formed as the last point is popped; the
    // divisor is the final inlier count, held for both divisions.
    crs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (stat_cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crs_pkg::B_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            rd_vld    <= 1'b0;
            d_vld     <= 1'b0;
            sq_vld    <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cnt_reg <= head.last ? '0 : cnt_fin;
                sum_reg <= head.last ? '0 : sum_fin;
            end
            rd_vld <= (state_reg == crs_pkg::B_SWEEP);
            d_vld  <= rd_vld && rd_reg[32];
            sq_vld <= d_vld;
            done   <= (pop && !head.last) || (state_reg == crs_pkg::B_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            store[head.idx] <= {head.inl, head.r};
            if (head.last)
            begin
                hold_reg     <= head;
                stat_cnt_reg <= cnt_fin;
                stat_sum_reg <= sum_fin;
            end
        end
        if (state_reg == crs_pkg::B_SWEEP)
        begin
            rd_reg <= store[sw_reg];
            sw_reg <= sw_reg + 1'b1;
        end
        d_reg  <= diff[32] ? 32'(-diff) : diff[31:0];
        sq_reg <= d_reg * d_reg;

        if (state_reg == crs_pkg::B_MEAN && div_done)
        begin
            mean_reg  <= stat_sum_reg[crs_pkg::SUM_W-1] ? 32'(-div_q[31:0]) : div_q[31:0];
            sw_reg    <= '0;
            sqacc_reg <= '0;
        end
        else if (sq_vld)
        begin
            sqacc_reg <= sqacc_reg + crs_pkg::SQ_W'(sq_reg);
        end

        // Bitwise integer square root, two radicand bits per step.
        if (state_reg == crs_pkg::B_VAR && div_done)
        begin
            v_reg   <= div_q[63:0];
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (state_reg == crs_pkg::B_SQRT)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (pop && !head.last)
        begin
            point_index   <= head.idx;
            is_inlier     <= head.inl;
            residual      <= head.r;
            summary_valid <= 1'b0;
            inlier_count  <= '0;
            mean_residual <= '0;
            std_residual  <= '0;
            no_inliers    <= 1'b0;
        end
        else if (state_reg == crs_pkg::B_EMIT)
        begin
            point_index   <= hold_reg.idx;
            is_inlier     <= hold_reg.inl;
            residual      <= hold_reg.r;
            summary_valid <= 1'b1;
            inlier_count  <= stat_cnt_reg;
            mean_residual <= (stat_cnt_reg == '0) ? '0 : mean_reg;
            std_residual  <= (stat_cnt_reg == '0) ? '0 : res_reg[30:0];
            no_inliers    <= (stat_cnt_reg == '0);
        end
    end

endmodule

// ===== rtl/conic_residual_inlier_stats.sv =====
// ============================================================================
// Conic residual inlier statistics
// Scores 2-D points against a configured conic and reports inlier statistics.
// ============================================================================
// A point is taken when start is high and busy is low. The front end scores
// one point at a time: eleven products go through one shared 33x33
// multiplier, then the sum and the threshold compare finish, the record waits
// while the queue is full; busy then drops until a point is taken. Each point
// gives one result, shown for one cycle with done high; the receiver cannot
// hold results off. A two-entry queue sits between scoring and the result
// side, so up to three further points are taken while a set's statistics
// run: two wait in the queue and one waits in the front end.
// The result of a set's last point (last_point high, or index 4095) comes
// after the statistics pass: the mean division, a sweep of the n stored
// residuals, the variance division and the square root. An empty inlier set
// skips all of that and reports no_inliers with zero mean and deviation.
// Configuration is written through cfg_valid/cfg_index/cfg_data and is
// always ready; write it only while no point is in flight.
module conic_residual_inlier_stats (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic               last_point,
    output logic               done,
    output logic [11:0]        point_index,
    output logic               is_inlier,
    output logic signed [31:0] residual,
    output logic               summary_valid,
    output logic [12:0]        inlier_count,
    output logic signed [31:0] mean_residual,
    output logic [30:0]        std_residual,
    output logic               no_inliers,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    crs_pkg::conic_cfg_t cfg_reg;
    crs_pkg::point_rec_t push_rec, head;
    logic                q_push, q_pop, q_empty, q_full;

    assign cfg_ready = 1'b1;

    // Register file; an index with no register behind it is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_a <= 32'sd65536;
            cfg_reg.coef_b <= 32'sd0;
            cfg_reg.coef_c <= 32'sd65536;
            cfg_reg.coef_d <= 32'sd0;
            cfg_reg.coef_e <= 32'sd0;
            cfg_reg.coef_f <= -32'sd65536;
            cfg_reg.thr    <= 31'd6554;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (crs_pkg::cfg_reg_t'(cfg_index))
                crs_pkg::REG_COEF_A:    cfg_reg.coef_a <= cfg_data;
                crs_pkg::REG_COEF_B:    cfg_reg.coef_b <= cfg_data;
                crs_pkg::REG_COEF_C:    cfg_reg.coef_c <= cfg_data;
                crs_pkg::REG_COEF_D:    cfg_reg.coef_d <= cfg_data;
                crs_pkg::REG_COEF_E:    cfg_reg.coef_e <= cfg_data;
                crs_pkg::REG_COEF_F:    cfg_reg.coef_f <= cfg_data;
                crs_pkg::REG_THRESHOLD: cfg_reg.thr    <= cfg_data[30:0];
                default:                ;
            endcase
        end
    end

    // Scoring side: residual, rounding, saturation and the inlier decision.
    crs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .last_point (last_point),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .busy       (busy),
        .rec_valid  (q_push),
        .rec        (push_rec)
    );

    crs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Result side: residual store, running sums and the end-of-set pass.
    crs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .done          (done),
        .point_index   (point_index),
        .is_inlier     (is_inlier),
        .residual      (residual),
        .summary_valid (summary_valid),
        .inlier_count  (inlier_count),
        .mean_residual (mean_residual),
        .std_residual  (std_residual),
        .no_inliers    (no_inliers)
    );

    // The queue is never written while full.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("record pushed into a full queue");

    // An accepted point keeps the front end busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("front end not busy after accepting a point");

    // An empty inlier set reports zero mean and deviation on a summary.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_inliers) |-> (summary_valid && mean_residual == 32'sd0
                                  && std_residual == 31'd0 && inlier_count == 13'd0))
        else $error("empty inlier set reported with nonzero statistics");

    // Results of points inside a set carry no statistics.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !summary_valid) |-> (inlier_count == 13'd0 && !no_inliers))
        else $error("statistics on a result that is not a summary");

endmodule

// ===== tb/conic_residual_inlier_stats_checker.sv =====
// ============================================================================
// Conic residual inlier statistics checker
// Watches the point, result and register channels, predicts every result and
// compares it field by field with what the block reports.
// ============================================================================
module conic_residual_inlier_stats_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic               last_point,
    input  logic               done,
    input  logic [11:0]        point_index,
    input  logic               is_inlier,
    input  logic signed [31:0] residual,
    input  logic               summary_valid,
    input  logic [12:0]        inlier_count,
    input  logic signed [31:0] mean_residual,
    input  logic [30:0]        std_residual,
    input  logic               no_inliers,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [11:0]        idx;
        logic               inl;
        logic signed [31:0] r;
        logic               summ;
        logic [12:0]        cnt;
        logic signed [31:0] mean;
        logic [30:0]        dev;
        logic               empty;
    } point_score_t;

    point_score_t        score_q[$];
    crs_pkg::conic_cfg_t conic;
    logic signed [31:0]  set_res[crs_pkg::MAX_POINTS];
    logic                set_inl[crs_pkg::MAX_POINTS];
    int                  set_pos;
    int                  set_inliers;
    longint              set_sum;

    // Exact conic value at 48 fraction bits, rounded half up, then saturated.
    function automatic logic signed [31:0] conic_value(logic signed [31:0] x,
                                                       logic signed [31:0] y);
        logic signed [127:0] ca, cb, cc, cd, ce, cf, px, py, acc;
        ca = conic.coef_a; cb = conic.coef_b; cc = conic.coef_c;
        cd = conic.coef_d; ce = conic.coef_e; cf = conic.coef_f;
        px = x;
        py = y;
        acc = ca * (px * px) + cb * (px * py) + cc * (py * py)
            + ((cd * px) <<< 16) + ((ce * py) <<< 16) + (cf <<< 32)
            + (128'sd1 <<< 31);
        acc = acc >>> 32;
        if (acc > 128'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (acc < -128'sd2147483648)
            return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic point_score_t score_point(logic signed [31:0] x,
                                                 logic signed [31:0] y,
                                                 logic lastp);
        point_score_t e;
        longint       mean, d;
        logic [127:0] sq;
        logic [63:0]  quo;
        e = '{default: '0};
        e.r = conic_value(x, y);
        e.inl = ((e.r < 0) ? -longint'(e.r) : longint'(e.r)) <= longint'(conic.thr);
        e.idx = set_pos[11:0];
        set_res[set_pos] = e.r;
        set_inl[set_pos] = e.inl;
        if (e.inl)
        begin
            set_inliers++;
            set_sum += e.r;
        end
        // A point in the final slot of the store closes the set by itself.
        if (lastp || set_pos == crs_pkg::MAX_POINTS - 1)
        begin
            e.summ = 1'b1;
            e.cnt = set_inliers[12:0];
            if (set_inliers == 0)
            begin
                e.empty = 1'b1;
            end
            else
            begin
                mean = set_sum / set_inliers;
                sq = 0;
                for (int i = 0; i <= set_pos; i++)
                begin
                    if (set_inl[i])
                    begin
                        d = longint'(set_res[i]) - mean;
                        if (d < 0)
                            d = -d;
                        sq += 128'(d) * 128'(d);
                    end
                end
                quo = 64'(sq / set_inliers);
                e.mean = mean[31:0];
                e.dev = 31'(floor_sqrt(quo));
            end
            set_pos = 0;
            set_inliers = 0;
            set_sum = 0;
        end
        else
        begin
            set_pos++;
        end
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_score_t e;
        if (!rst_n)
        begin
            conic.coef_a <= 32'sd65536;
            conic.coef_b <= 32'sd0;
            conic.coef_c <= 32'sd65536;
            conic.coef_d <= 32'sd0;
            conic.coef_e <= 32'sd0;
            conic.coef_f <= -32'sd65536;
            conic.thr <= 31'd6554;
            set_pos = 0;
            set_inliers = 0;
            set_sum = 0;
            score_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (score_q.size() == 0)
                begin
                    report_mismatch("unexpected result, index", point_index, -1);
                end
                else
                begin
                    e = score_q.pop_front();
                    if (point_index !== e.idx)
                        report_mismatch("point_index", point_index, e.idx);
                    if (is_inlier !== e.inl)
                        report_mismatch("is_inlier", is_inlier, e.inl);
                    if (residual !== e.r)
                        report_mismatch("residual", residual, e.r);
                    if (summary_valid !== e.summ)
                        report_mismatch("summary_valid", summary_valid, e.summ);
                    if (inlier_count !== e.cnt)
                        report_mismatch("inlier_count", inlier_count, e.cnt);
                    if (mean_residual !== e.mean)
                        report_mismatch("mean_residual", mean_residual, e.mean);
                    if (std_residual !== e.dev)
                        report_mismatch("std_residual", std_residual, e.dev);
                    if (no_inliers !== e.empty)
                        report_mismatch("no_inliers", no_inliers, e.empty);
                end
            end
            if (start && !busy)
                score_q.insert(score_q.size(), score_point(x_coord, y_coord, last_point));
            if (cfg_valid && cfg_ready)
            begin
                case (crs_pkg::cfg_reg_t'(cfg_index))
                    crs_pkg::REG_COEF_A:    conic.coef_a <= cfg_data;
                    crs_pkg::REG_COEF_B:    conic.coef_b <= cfg_data;
                    crs_pkg::REG_COEF_C:    conic.coef_c <= cfg_data;
                    crs_pkg::REG_COEF_D:    conic.coef_d <= cfg_data;
                    crs_pkg::REG_COEF_E:    conic.coef_e <= cfg_data;
                    crs_pkg::REG_COEF_F:    conic.coef_f <= cfg_data;
                    crs_pkg::REG_THRESHOLD: conic.thr <= cfg_data[30:0];
                    default:                ;
                endcase
            end
            pending = score_q.size();
        end
    end

endmodule

// ===== tb/conic_residual_inlier_stats_tb.sv =====
// ============================================================================
// Conic residual inlier statistics testbench
// Drives points and register writes into the block, with random gaps, and
// lets the checker beside it predict and compare every result.
// ============================================================================
module conic_residual_inlier_stats_tb;

    // Index 7 is not a register; writes to it must leave the conic alone.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         RANDOM_POINTS = 500;

    // Point shapes used by the random part.
    typedef enum int {
        PT_FULL,
        PT_NEAR,
        PT_EDGE
    } point_shape_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic               last_point;
    logic               done;
    logic [11:0]        point_index;
    logic               is_inlier;
    logic signed [31:0] residual;
    logic               summary_valid;
    logic [12:0]        inlier_count;
    logic signed [31:0] mean_residual;
    logic [30:0]        std_residual;
    logic               no_inliers;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 errors;
    int                 pending;
    int                 cycles;
    bit                 quiet;

    conic_residual_inlier_stats u_dut (.*);
    conic_residual_inlier_stats_checker u_chk (.*);

    always #6 clk = ~clk;

    // A hard limit on the run; it only fires when the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Hands one point over. Inputs move on the falling edge and the request is
    // taken on the first rising edge that sees busy low. Start stays high
    // afterwards so that back-to-back points leave no hole.
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic lastp);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        start = 1'b1;
        x_coord = x;
        y_coord = y;
        last_point = lastp;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Registers may only change with no point in flight, so every write waits
    // until each predicted result has come back and the block has settled.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_conic(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] d, logic [31:0] e, logic [31:0] f,
                              logic [31:0] thr);
        write_reg(crs_pkg::REG_COEF_A, a);
        write_reg(crs_pkg::REG_COEF_B, b);
        write_reg(crs_pkg::REG_COEF_C, c);
        write_reg(crs_pkg::REG_COEF_D, d);
        write_reg(crs_pkg::REG_COEF_E, e);
        write_reg(crs_pkg::REG_COEF_F, f);
        write_reg(crs_pkg::REG_THRESHOLD, thr);
    endtask

    function automatic logic [31:0] pick_coord(point_shape_t shape);
        case (shape)
            PT_FULL: return $urandom;
            PT_NEAR: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
        endcase
    endfunction

    // Sends a run of random points; short sets keep the statistics busy.
    task automatic send_random_points(int count, point_shape_t shape, int set_odds);
        for (int i = 0; i < count; i++)
            send_point(pick_coord(shape), pick_coord(shape),
                       $urandom_range(0, set_odds - 1) == 0);
        send_point(pick_coord(shape), pick_coord(shape), 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        x_coord = '0;
        y_coord = '0;
        last_point = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = crs_pkg::REG_COEF_A;
        cfg_data = '0;
        cycles = 0;
        quiet = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, default unit circle first: a point on the circle, the
        // origin and the coordinate extremes, which saturate to the largest value.
        send_point(32'sh0001_0000, 32'sd0, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);

        // A set with no inliers at all.
        send_point(32'sh0100_0000, 32'sd0, 1'b1);

        // Threshold moved in the middle of a set; the earlier point keeps its
        // decision. The unused register index must change nothing.
        send_point(32'sh0001_2000, 32'sd0, 1'b0);
        write_reg(crs_pkg::REG_THRESHOLD, 32'h0001_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_point(32'sh0001_2000, 32'sd0, 1'b1);

        // Constant conic: residual equals F, so the threshold edge is exact.
        load_conic(0, 0, 0, 0, 0, 32'd6554, 32'd6554);
        send_point(32'sd5, 32'sd7, 1'b0);
        write_reg(crs_pkg::REG_COEF_F, 32'd6555);
        send_point(32'sd5, 32'sd7, 1'b0);
        write_reg(crs_pkg::REG_COEF_F, -32'sd6554);
        send_point(32'sd5, 32'sd7, 1'b1);

        // Half-LSB ties round toward plus infinity.
        load_conic(0, 0, 0, 32'd1, 32'd1, 0, 32'd1);
        send_point(32'sh0000_8000, 32'sd0, 1'b0);
        send_point(-32'sh0000_8000, 32'sd0, 1'b0);
        send_point(32'sd0, -32'sh0000_8000, 1'b1);

        // Extreme coefficients with the widest threshold.
        load_conic(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'sd1, 32'sd1, 1'b0);
        send_point(32'sh0000_0100, -32'sh0000_0100, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);

        // Random part: near-circle points give a good mix of inliers.
        load_conic(32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 32'hFFFF_C000,
                   32'h0000_2000, 32'hFFFF_0000, 32'h0002_0000);
        send_random_points(150, PT_NEAR, 12);
        load_conic($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
        send_random_points(80, PT_FULL, 8);
        load_conic(0, 0, 0, $urandom_range(0, 32'h0000_FFFF), $urandom_range(0, 32'h0000_FFFF),
                   $urandom, 32'h7FFF_FFFF);
        send_random_points(80, PT_EDGE, 6);
        load_conic(32'h0000_8000, 0, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 32'h0000_8000);
        send_random_points(80, PT_NEAR, 10);

        // Last stretch runs with no gaps at all.
        quiet = 1'b1;
        send_random_points(RANDOM_POINTS - 390, PT_NEAR, 9);
        start = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/crs_pkg.sv
rtl/crs_front.sv
rtl/crs_queue.sv
rtl/crs_div.sv
rtl/crs_back.sv
rtl/conic_residual_inlier_stats.sv
tb/conic_residual_inlier_stats_checker.sv
tb/conic_residual_inlier_stats_tb.sv
